[rtl/lcad_pkg.sv]
package lcad_pkg;

  localparam int NODE_W    = 10;
  localparam int MAX_NODES = 1 << NODE_W;
  localparam int LEVELS    = 10;
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ANC_AW    = NODE_W + LVL_W;
  localparam int ANC_DEPTH = 1 << ANC_AW;

  localparam int WEIGHT_W = 16;
  localparam int DEPTH_W  = 11;
  localparam int DIST_W   = 26;
  localparam int CMP_W    = ((DEPTH_W > LEVELS) ? DEPTH_W : LEVELS) + 1;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [NODE_W-1:0] node_t;

  typedef struct packed {
    logic [DIST_W-1:0]  root_dist;
    logic [DEPTH_W-1:0] depth;
  } node_info_t;

  // Out-of-range node numbers fold to node 0 (no node).
  function automatic node_t node_index(input node_t n);
    return (int'(n) < MAX_NODES) ? n : '0;
  endfunction

endpackage

[rtl/tree_lca_distance_query.sv]
// Weighted rooted tree with lowest-common-ancestor and path-distance queries.
// Input transfers carry kind in s_axis_tuser (0 = add node, 1 = query). An add
// stores node_a with parent node_b (0 = root) and its edge weight; parents
// must be added before children. A query of node_a and node_b returns one
// result transfer with their common ancestor and weighted path distance.
// Items are handled one at a time; s_axis_tready is high only between items.
// An add writes one ancestor-table entry per lifting level. A query lifts the
// deeper node level by level, then, when the two nodes still differ at equal
// depth, jumps both nodes level by level to just below their common ancestor;
// a finished query may wait for the output register. The ancestor-table and
// node-info memories have registered reads, read once or twice per level.
// A finished result waits in the output register while the next item runs.
module tree_lca_distance_query (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // node_a[9:0], node_b[19:10], edge_weight[35:20], zero fill
  input  logic [lcad_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // common_ancestor[9:0], path_distance[35:10], zero fill
  output logic [lcad_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADD0 = 4'd1;
  localparam logic [3:0] S_ADDL = 4'd2;
  localparam logic [3:0] S_QRA  = 4'd3;
  localparam logic [3:0] S_QRB  = 4'd4;
  localparam logic [3:0] S_LIFT = 4'd5;
  localparam logic [3:0] S_LANC = 4'd6;
  localparam logic [3:0] S_LDEP = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_JUMP = 4'd9;
  localparam logic [3:0] S_PAR  = 4'd10;
  localparam logic [3:0] S_DIST = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  localparam logic [lcad_pkg::LVL_W-1:0] LVL_TOP = lcad_pkg::LVL_W'(lcad_pkg::LEVELS - 1);
  localparam logic [lcad_pkg::LVL_W-1:0] LVL_ONE = lcad_pkg::LVL_W'(1);

  // memories
  logic [lcad_pkg::NODE_W-1:0] anc_mem [0:lcad_pkg::ANC_DEPTH-1];
  lcad_pkg::node_info_t        info_mem [0:lcad_pkg::MAX_NODES-1];

  logic [3:0]                   state;
  logic [lcad_pkg::LVL_W-1:0]   lvl;
  lcad_pkg::node_t              add_node;
  lcad_pkg::node_t              add_parent;
  logic [lcad_pkg::WEIGHT_W-1:0] add_weight;
  lcad_pkg::node_t              ca;
  lcad_pkg::node_t              cb;
  logic [lcad_pkg::DEPTH_W-1:0] dep_a;
  logic [lcad_pkg::DEPTH_W-1:0] dep_b;
  logic [lcad_pkg::DIST_W-1:0]  dist_a0;
  logic [lcad_pkg::DIST_W-1:0]  dist_b0;
  lcad_pkg::node_t              lca;
  logic [lcad_pkg::DIST_W-1:0]  dist_l;

  // memory ports
  logic [lcad_pkg::ANC_AW-1:0]  anc_ra_a;
  logic [lcad_pkg::ANC_AW-1:0]  anc_ra_b;
  logic [lcad_pkg::ANC_AW-1:0]  anc_wa;
  lcad_pkg::node_t              anc_wd;
  logic                         anc_we;
  lcad_pkg::node_t              anc_q_a;
  lcad_pkg::node_t              anc_q_b;
  logic                         anc_zero_a;
  logic                         anc_zero_b;
  logic                         anc_fwd;
  lcad_pkg::node_t              anc_fwd_d;
  lcad_pkg::node_t              anc_a;
  lcad_pkg::node_t              anc_b;

  lcad_pkg::node_t              info_ra;
  lcad_pkg::node_t              info_wa;
  lcad_pkg::node_info_t         info_wd;
  logic                         info_we;
  lcad_pkg::node_info_t         info_q;
  logic                         info_zero;
  lcad_pkg::node_info_t         info_rd;

  logic                         accept;
  lcad_pkg::node_t              in_a;
  lcad_pkg::node_t              in_b;
  logic [lcad_pkg::CMP_W-1:0]   lift_need;
  logic                         lift_go;
  lcad_pkg::node_t              jump_a;
  lcad_pkg::node_t              jump_b;
  logic [lcad_pkg::DEPTH_W-1:0] new_depth;
  logic [lcad_pkg::DIST_W:0]    dist_sum;
  logic [lcad_pkg::DIST_W-1:0]  new_dist;
  logic [lcad_pkg::DIST_W:0]    pair_sum;
  logic [lcad_pkg::DIST_W:0]    twice_l;
  logic [lcad_pkg::DIST_W:0]    path_diff;
  logic [lcad_pkg::DIST_W-1:0]  path_dist;
  logic                         out_load;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_a          = s_axis_tdata[lcad_pkg::NODE_W-1:0];
  assign in_b          = s_axis_tdata[2*lcad_pkg::NODE_W-1:lcad_pkg::NODE_W];

  // node 0 is never written and reads as all zero
  assign anc_a   = anc_zero_a ? '0 : (anc_fwd ? anc_fwd_d : anc_q_a);
  assign anc_b   = anc_zero_b ? '0 : anc_q_b;
  assign info_rd = info_zero ? '0 : info_q;

  always_ff @(posedge clk) begin
    if (anc_we) begin
      anc_mem[anc_wa] <= anc_wd;
    end
    anc_q_a    <= anc_mem[anc_ra_a];
    anc_q_b    <= anc_mem[anc_ra_b];
    anc_zero_a <= (anc_ra_a[lcad_pkg::ANC_AW-1:lcad_pkg::LVL_W] == '0);
    anc_zero_b <= (anc_ra_b[lcad_pkg::ANC_AW-1:lcad_pkg::LVL_W] == '0);
    // a port-a read of the entry written in the same cycle returns the new value
    anc_fwd    <= anc_we && (anc_wa == anc_ra_a);
    anc_fwd_d  <= anc_wd;
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_wa] <= info_wd;
    end
    info_q    <= info_mem[info_ra];
    info_zero <= (info_ra == '0);
  end

  // add: depth and root distance from the parent, saturating
  always_comb begin
    new_depth = (info_rd.depth == lcad_pkg::DEPTH_MAX) ? lcad_pkg::DEPTH_MAX
                                                        : info_rd.depth + 1'b1;
    dist_sum  = {1'b0, info_rd.root_dist} + (lcad_pkg::DIST_W+1)'(add_weight);
    new_dist  = dist_sum[lcad_pkg::DIST_W] ? lcad_pkg::DIST_MAX
                                           : dist_sum[lcad_pkg::DIST_W-1:0];
  end

  always_comb begin
    lift_need = lcad_pkg::CMP_W'(dep_b) + (lcad_pkg::CMP_W'(1) << lvl);
    lift_go   = (lcad_pkg::CMP_W'(dep_a) >= lift_need);
    jump_a    = (anc_a != anc_b) ? anc_a : ca;
    jump_b    = (anc_a != anc_b) ? anc_b : cb;
  end

  always_comb begin
    pair_sum  = {1'b0, dist_a0} + {1'b0, dist_b0};
    twice_l   = {dist_l, 1'b0};
    path_diff = (pair_sum >= twice_l) ? pair_sum - twice_l : '0;
    path_dist = path_diff[lcad_pkg::DIST_W] ? lcad_pkg::DIST_MAX
                                            : path_diff[lcad_pkg::DIST_W-1:0];
    out_load  = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);
  end

  // memory addressing
  always_comb begin
    anc_ra_a = {ca, lvl};
    anc_ra_b = {cb, lvl};
    anc_we   = 1'b0;
    anc_wa   = {add_node, lvl};
    anc_wd   = anc_a;
    info_ra  = ca;
    info_we  = 1'b0;
    info_wa  = add_node;
    info_wd  = '{root_dist: new_dist, depth: new_depth};
    unique case (state)
      S_IDLE: begin
        info_ra = lcad_pkg::node_index(in_a);
      end
      S_ADD0: begin
        anc_we   = 1'b1;
        anc_wa   = {add_node, lcad_pkg::LVL_W'(0)};
        anc_wd   = add_parent;
        anc_ra_a = {add_parent, lcad_pkg::LVL_W'(0)};
        info_ra  = add_parent;
      end
      S_ADDL: begin
        anc_we   = (int'(lvl) < lcad_pkg::LEVELS);
        anc_ra_a = {anc_a, lvl};
        info_we  = (lvl == LVL_ONE);
      end
      S_QRA: begin
        info_ra = cb;
      end
      S_LANC: begin
        info_ra = anc_a;
      end
      S_CMP: begin
        anc_ra_a = {ca, LVL_TOP};
        anc_ra_b = {cb, LVL_TOP};
      end
      S_JUMP: begin
        anc_ra_a = {jump_a, lvl - LVL_ONE};
        anc_ra_b = {jump_b, lvl - LVL_ONE};
        if (lvl == '0) begin
          anc_ra_a = {jump_a, lcad_pkg::LVL_W'(0)};
        end
      end
      S_PAR: begin
        info_ra = anc_a;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_axis_tuser == lcad_pkg::KIND_QUERY) begin
              state <= S_QRA;
            end else if (in_a != '0 && int'(in_a) < lcad_pkg::MAX_NODES) begin
              state <= S_ADD0;
            end
          end
        end
        S_ADD0: state <= S_ADDL;
        S_ADDL: begin
          if (int'(lvl) >= lcad_pkg::LEVELS - 1) begin
            state <= S_IDLE;
          end
        end
        S_QRA: state <= S_QRB;
        S_QRB: state <= S_LIFT;
        S_LIFT: begin
          if (lift_go) begin
            state <= S_LANC;
          end else if (lvl == '0) begin
            state <= S_CMP;
          end
        end
        S_LANC: state <= S_LDEP;
        S_LDEP: state <= (lvl == '0) ? S_CMP : S_LIFT;
        S_CMP:  state <= (ca == cb) ? S_DIST : S_JUMP;
        S_JUMP: begin
          if (lvl == '0) begin
            state <= S_PAR;
          end
        end
        S_PAR:  state <= S_DIST;
        S_DIST: state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        add_node   <= in_a;
        add_parent <= lcad_pkg::node_index(in_b);
        add_weight <= s_axis_tdata[2*lcad_pkg::NODE_W+lcad_pkg::WEIGHT_W-1:
                                   2*lcad_pkg::NODE_W];
        ca         <= lcad_pkg::node_index(in_a);
        cb         <= lcad_pkg::node_index(in_b);
      end
      S_ADD0: lvl <= LVL_ONE;
      S_ADDL: lvl <= lvl + LVL_ONE;
      S_QRA: begin
        dep_a   <= info_rd.depth;
        dist_a0 <= info_rd.root_dist;
      end
      S_QRB: begin
        dist_b0 <= info_rd.root_dist;
        lvl     <= LVL_TOP;
        // keep the deeper node in ca
        if (dep_a < info_rd.depth) begin
          ca    <= cb;
          cb    <= ca;
          dep_a <= info_rd.depth;
          dep_b <= dep_a;
        end else begin
          dep_b <= info_rd.depth;
        end
      end
      S_LIFT: begin
        if (!lift_go && lvl != '0) begin
          lvl <= lvl - LVL_ONE;
        end
      end
      S_LANC: ca <= anc_a;
      S_LDEP: begin
        dep_a <= info_rd.depth;
        if (lvl != '0) begin
          lvl <= lvl - LVL_ONE;
        end
      end
      S_CMP: begin
        lca <= ca;
        lvl <= LVL_TOP;
      end
      S_JUMP: begin
        ca <= jump_a;
        cb <= jump_b;
        if (lvl != '0) begin
          lvl <= lvl - LVL_ONE;
        end
      end
      S_PAR:  lca <= anc_a;
      S_DIST: dist_l <= info_rd.root_dist;
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= lcad_pkg::OUT_DATA_W'({path_dist, lca});
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;

  typedef lcad_pkg::node_t node_t;

  localparam int MAX_NODES  = lcad_pkg::MAX_NODES;
  localparam int LEVELS     = lcad_pkg::LEVELS;
  localparam int WEIGHT_W   = lcad_pkg::WEIGHT_W;
  localparam int DEPTH_W    = lcad_pkg::DEPTH_W;
  localparam int DIST_W     = lcad_pkg::DIST_W;
  localparam int IN_DATA_W  = lcad_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = lcad_pkg::OUT_DATA_W;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = lcad_pkg::DEPTH_MAX;
  localparam logic [DIST_W-1:0]  DIST_MAX  = lcad_pkg::DIST_MAX;
  localparam logic KIND_ADD   = lcad_pkg::KIND_ADD;
  localparam logic KIND_QUERY = lcad_pkg::KIND_QUERY;

  localparam int RAND_ITEMS   = 500;
  localparam int SAT_ADDS     = 1030;
  localparam int STUCK_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int DIR_N        = 25;

  typedef struct packed {
    node_t             anc;
    logic [DIST_W-1:0] path;
  } path_result_t;

  typedef struct packed {
    logic                kind;
    node_t               a;
    node_t               b;
    logic [WEIGHT_W-1:0] w;
    logic                typed;
    node_t               exp_anc;
    logic [DIST_W-1:0]   exp_dist;
  } dir_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // node_a[9:0], node_b[19:10], edge_weight[35:20], zero fill
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // kind
  logic                  s_axis_tuser = KIND_ADD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // common_ancestor[9:0], path_distance[35:10], zero fill
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // shadow copy of the lifting tables
  node_t              anc_tbl [MAX_NODES][LEVELS];
  logic [DEPTH_W-1:0] depth_tbl [MAX_NODES];
  logic [DIST_W-1:0]  dist_tbl [MAX_NODES];
  bit                 is_added [MAX_NODES];
  node_t              added_q [$];
  node_t              last_added;

  path_result_t path_due_q [$];
  path_result_t due_res;
  int           errors = 0;
  bit           idle_en = 1'b1;
  int           sink_hold = 0;
  int           stuck;

  dir_row_t dir_rows [DIR_N] = '{
    '{KIND_ADD,   10'd1,    10'd0,    16'd0,      1'b0, 10'd0, 26'd0},
    '{KIND_QUERY, 10'd1,    10'd1,    16'd0,      1'b1, 10'd1, 26'd0},
    '{KIND_QUERY, 10'd0,    10'd0,    16'd0,      1'b1, 10'd0, 26'd0},
    '{KIND_ADD,   10'd1023, 10'd1,    16'hFFFF,   1'b0, 10'd0, 26'd0},
    '{KIND_QUERY, 10'd1023, 10'd1,    16'd0,      1'b1, 10'd1, 26'd65535},
    '{KIND_QUERY, 10'd1,    10'd1023, 16'd0,      1'b1, 10'd1, 26'd65535},
    '{KIND_QUERY, 10'd1023, 10'd0,    16'd0,      1'b1, 10'd0, 26'd65535},
    '{KIND_ADD,   10'd0,    10'd1023, 16'hFFFF,   1'b0, 10'd0, 26'd0},
    '{KIND_ADD,   10'd2,    10'd0,    16'd100,    1'b0, 10'd0, 26'd0},
    '{KIND_QUERY, 10'd2,    10'd1023, 16'd0,      1'b1, 10'd0, 26'd65635},
    '{KIND_ADD,   10'd3,    10'd2,    16'd7,      1'b0, 10'd0, 26'd0},
    '{KIND_ADD,   10'd4,    10'd2,    16'd9,      1'b0, 10'd0, 26'd0},
    '{KIND_ADD,   10'd5,    10'd3,    16'd1,      1'b0, 10'd0, 26'd0},
    '{KIND_QUERY, 10'd5,    10'd4,    16'd0,      1'b0, 10'd0, 26'd0},
    '{KIND_ADD,   10'd6,    10'd1023, 16'hFFFF,   1'b0, 10'd0, 26'd0},
    '{KIND_QUERY, 10'd6,    10'd5,    16'd0,      1'b0, 10'd0, 26'd0},
    '{KIND_ADD,   10'd3,    10'd1023, 16'd5,      1'b0, 10'd0, 26'd0},
    '{KIND_QUERY, 10'd5,    10'd3,    16'd0,      1'b0, 10'd0, 26'd0},
    '{KIND_QUERY, 10'd3,    10'd4,    16'd0,      1'b0, 10'd0, 26'd0},
    '{KIND_ADD,   10'd512,  10'd6,    16'h5555,   1'b0, 10'd0, 26'd0},
    '{KIND_ADD,   10'd768,  10'd512,  16'hAAAA,   1'b0, 10'd0, 26'd0},
    '{KIND_QUERY, 10'd768,  10'd1,    16'd0,      1'b0, 10'd0, 26'd0},
    '{KIND_ADD,   10'd2,    10'd2,    16'd1,      1'b0, 10'd0, 26'd0},
    '{KIND_QUERY, 10'd2,    10'd4,    16'd0,      1'b0, 10'd0, 26'd0},
    '{KIND_QUERY, 10'd4,    10'd768,  16'd0,      1'b0, 10'd0, 26'd0}
  };

  tree_lca_distance_query dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void graft_node(node_t n, node_t p, logic [WEIGHT_W-1:0] w);
    node_t           mid;
    int unsigned     d;
    longint unsigned s;
    anc_tbl[n][0] = p;
    // later levels read what was just written, so a self-parent chains onto itself
    for (int k = 1; k < LEVELS; k++) begin
      mid = anc_tbl[n][k-1];
      anc_tbl[n][k] = anc_tbl[mid][k-1];
    end
    d = (p == '0) ? 1 : int'(depth_tbl[p]) + 1;
    if (d > DEPTH_MAX) d = DEPTH_MAX;
    s = (p == '0) ? longint'(w) : longint'(dist_tbl[p]) + longint'(w);
    if (s > DIST_MAX) s = DIST_MAX;
    depth_tbl[n] = d[DEPTH_W-1:0];
    dist_tbl[n]  = s[DIST_W-1:0];
  endfunction

  function automatic int depth_at(node_t n);
    return (n == '0) ? 0 : int'(depth_tbl[n]);
  endfunction

  function automatic longint unsigned dist_at(node_t n);
    return (n == '0) ? 0 : longint'(dist_tbl[n]);
  endfunction

  function automatic node_t meet_point(node_t a, node_t b);
    node_t x;
    node_t y;
    node_t t;
    x = a;
    y = b;
    if (depth_at(x) < depth_at(y)) begin
      t = x;
      x = y;
      y = t;
    end
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (depth_at(x) >= depth_at(y) + (1 << k)) x = anc_tbl[x][k];
    end
    if (x == y) return x;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (anc_tbl[x][k] != anc_tbl[y][k]) begin
        x = anc_tbl[x][k];
        y = anc_tbl[y][k];
      end
    end
    return anc_tbl[x][0];
  endfunction

  function automatic path_result_t predict_path(node_t a, node_t b);
    path_result_t    r;
    longint unsigned sum;
    longint unsigned twice;
    r.anc = meet_point(a, b);
    sum   = dist_at(a) + dist_at(b);
    twice = 2 * dist_at(r.anc);
    sum   = (sum >= twice) ? sum - twice : 0;
    if (sum > DIST_MAX) sum = DIST_MAX;
    r.path = sum[DIST_W-1:0];
    return r;
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return WEIGHT_W'($urandom_range(0, 65535));
  endfunction

  function automatic node_t pick_known();
    if ($urandom_range(0, 19) == 0) return '0;
    return added_q[$urandom_range(0, added_q.size() - 1)];
  endfunction

  task automatic offer_item(logic kind, node_t a, node_t b, logic [WEIGHT_W-1:0] w,
                            bit typed, path_result_t typed_res);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(IN_DATA_W - 36){1'b0}}, w, b, a};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (kind == KIND_ADD) begin
      if (a != '0) begin
        graft_node(a, b, w);
        if (!is_added[a]) begin
          is_added[a] = 1'b1;
          added_q.insert(added_q.size(), a);
        end
        last_added = a;
      end
    end else begin
      path_due_q.insert(path_due_q.size(), typed ? typed_res : predict_path(a, b));
    end
    if (idle_en && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // result side: random stall bursts while idle_en is set
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= 0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= $urandom_range(0, 6);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (path_due_q.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual anc %0d dist %0d",
                 $time, m_axis_tdata[9:0], m_axis_tdata[35:10]);
        errors++;
      end else begin
        due_res = path_due_q.pop_front();
        if (m_axis_tdata[9:0] !== due_res.anc) begin
          $display("%0t: common_ancestor expected %0d actual %0d",
                   $time, due_res.anc, m_axis_tdata[9:0]);
          errors++;
        end
        if (m_axis_tdata[35:10] !== due_res.path) begin
          $display("%0t: path_distance expected %0d actual %0d",
                   $time, due_res.path, m_axis_tdata[35:10]);
          errors++;
        end
      end
    end
  end

  initial begin
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stuck = 0;
      else stuck++;
    end
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    int                  rand_items;
    int                  pick;
    int                  sel;
    node_t               qa;
    node_t               qb;
    logic [WEIGHT_W-1:0] wt;
    path_result_t        typed_res;

    for (int n = 0; n < MAX_NODES; n++) begin
      for (int k = 0; k < LEVELS; k++) anc_tbl[n][k] = '0;
      depth_tbl[n] = '0;
      dist_tbl[n]  = '0;
      is_added[n]  = 1'b0;
    end
    last_added = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      typed_res.anc  = dir_rows[i].exp_anc;
      typed_res.path = dir_rows[i].exp_dist;
      offer_item(dir_rows[i].kind, dir_rows[i].a, dir_rows[i].b, dir_rows[i].w,
                 dir_rows[i].typed, typed_res);
    end

    // self-parent re-adds grow depth and distance by one edge each, up to distance saturation
    offer_item(KIND_ADD, 10'd7, 10'd0, 16'hFFFF, 1'b0, '0);
    for (int i = 0; i < SAT_ADDS; i++) begin
      offer_item(KIND_ADD, 10'd7, 10'd7, 16'hFFFF, 1'b0, '0);
      if (i % 256 == 255) offer_item(KIND_QUERY, 10'd7, 10'd1023, '0, 1'b0, '0);
    end
    offer_item(KIND_ADD, 10'd8, 10'd7, 16'hFFFF, 1'b0, '0);
    offer_item(KIND_QUERY, 10'd8, 10'd1023, '0, 1'b0, '0);
    offer_item(KIND_QUERY, 10'd8, 10'd8, '0, 1'b0, '0);
    offer_item(KIND_QUERY, 10'd1, 10'd8, '0, 1'b0, '0);
    offer_item(KIND_ADD, 10'd7, 10'd0, 16'h1234, 1'b0, '0);
    offer_item(KIND_ADD, 10'd8, 10'd7, 16'd1, 1'b0, '0);

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      idle_en = !((rand_items >= 150 && rand_items < 250) || rand_items >= RAND_ITEMS - 150);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // node zero add, dropped by the block
        offer_item(KIND_ADD, '0, node_t'($urandom_range(0, 1023)), rand_weight(), 1'b0, '0);
      end else if (pick < 45) begin
        qa  = node_t'($urandom_range(1, 1023));
        sel = $urandom_range(0, 9);
        if (sel < 2) qb = '0;
        else if (sel < 6) qb = last_added;
        else qb = added_q[$urandom_range(0, added_q.size() - 1)];
        wt = rand_weight();
        offer_item(KIND_ADD, qa, qb, wt, 1'b0, '0);
        rand_items++;
      end else begin
        qa = pick_known();
        qb = pick_known();
        offer_item(KIND_QUERY, qa, qb, '0, 1'b0, '0);
        rand_items++;
      end
    end

    s_axis_tvalid <= 1'b0;
    idle_en = 1'b0;
    while (path_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && path_due_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lcad_pkg.sv
rtl/tree_lca_distance_query.sv
dv/tb.sv
